@@ design/skfo_pkg.sv @@
package skfo_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned KEY_BITS_DEF    = 44;

  // Fixed field widths
  localparam int unsigned LOAD_IDX_W = 12;
  localparam int unsigned LOAD_KEY_W = 44;
  localparam int unsigned CODE_W     = 64;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned OBJ_W      = 6;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [OBJ_W-1:0] OBJ_BITS_RESET = 6'd20;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd1;

  typedef struct packed {
    logic                  operation;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [LOAD_KEY_W-1:0] load_key;
    logic [CODE_W-1:0]     query_code;
    logic                  new_batch;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_UPDATE,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Sequencer to search unit
  typedef struct packed {
    logic start;   // capture target, open bounds
    logic update;  // apply probe compare to bounds
    logic finish;  // loop ended, save lower bound
    logic check;   // compare entry at bound against target
  } ctrl_t;

  // Search unit to sequencer
  typedef struct packed {
    logic loop_go;   // low < high
    logic in_range;  // low < clipped length
  } stat_t;

endpackage

@@ design/sorted_key_first_occurrence_search.sv @@
// Leftmost binary search over a table of ascending keys.
// Input channel (in_valid_i/in_ready_o, payload in_i): a load transaction
// writes load_key at load_index and gives no result; a query transaction
// shifts query_code right by object_bits and searches for the first entry
// not below that target, starting at the lower bound kept from the previous
// query (zero when new_batch is set). One result per query leaves on the
// output channel (out_valid_o/out_ready_i, payload out_o).
// Steps: a query alternates the PROBE and UPDATE states once per probe
// (the table RAM has a registered read port and the next probe address
// depends on the compare), then, if the lower bound lies below the table
// length, runs the final equality check in CHECK, and posts the result
// from DONE. A query is accepted only while no search runs.
// The output register lets the next transaction be accepted while a result
// waits; a finished search holds until the output register is free.
// Reset clears the sequencer, the carried lower bound, the output valid and
// the registers (object_bits = 20, table_length = 0); table contents are
// undefined until loaded. Configuration writes take effect at once.
module sorted_key_first_occurrence_search #(
  parameter int unsigned TABLE_DEPTH = skfo_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = skfo_pkg::KEY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [skfo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [skfo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  skfo_pkg::in_t                    in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output skfo_pkg::out_t                   out_o
);

  import skfo_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [OBJ_W-1:0] obj_bits_q;
  logic [LEN_W-1:0] tab_len_q;
  ctrl_t            ctrl;
  stat_t            stat;
  out_t             result, out_q;
  logic             out_valid_q, out_valid_d, out_load, out_free;
  logic             load_we;
  logic [AW-1:0]    raddr;
  logic [KEY_BITS-1:0] rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_bits_q <= OBJ_BITS_RESET;
      tab_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OBJECT_BITS:  obj_bits_q <= cfg_data_i[OBJ_W-1:0];
        CFG_TABLE_LENGTH: tab_len_q  <= cfg_data_i[LEN_W-1:0];
        default: begin
          obj_bits_q <= obj_bits_q;
        end
      endcase
    end
  end

  // Table loads; out-of-range indexes are dropped
  assign load_we = in_valid_i && in_ready_o && (in_i.operation == OP_LOAD)
                   && (32'(in_i.load_index) < 32'(TABLE_DEPTH));

  skfo_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(in_i.load_index)),
    .wdata_i (KEY_BITS'(in_i.load_key)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  skfo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .out_load_o (out_load)
  );

  skfo_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .code_i      (in_i.query_code),
    .new_batch_i (in_i.new_batch),
    .obj_bits_i  (obj_bits_q),
    .tab_len_i   (tab_len_q),
    .rdata_i     (rdata),
    .raddr_o     (raddr),
    .stat_o      (stat),
    .result_o    (result)
  );

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  // A query transaction makes the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_i.operation == OP_QUERY)) |=> !in_ready_o)
    else $error("query accepted but block still ready");

  // A load transaction leaves the block ready
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_i.operation == OP_LOAD)) |=> in_ready_o)
    else $error("load transaction left the block busy");

  // A new result only appears after a search cycle
  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result posted without a search");
`endif

endmodule

@@ design/skfo_ram.sv @@
module skfo_ram #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/skfo_search.sv @@
module skfo_search #(
  parameter int unsigned TABLE_DEPTH = skfo_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = skfo_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skfo_pkg::ctrl_t                ctrl_i,
  input  logic [skfo_pkg::CODE_W-1:0]    code_i,
  input  logic                           new_batch_i,
  input  logic [skfo_pkg::OBJ_W-1:0]     obj_bits_i,
  input  logic [skfo_pkg::LEN_W-1:0]     tab_len_i,
  input  logic [KEY_BITS-1:0]            rdata_i,
  output logic [$clog2(TABLE_DEPTH)-1:0] raddr_o,
  output skfo_pkg::stat_t                stat_o,
  output skfo_pkg::out_t                 result_o
);

  import skfo_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

  logic [LW-1:0]     low_q, low_d, high_q, high_d, sl_q, sl_d;
  logic [LW-1:0]     len_clip, span, mid;
  logic [CODE_W-1:0] target_q, target_d, key_ext;
  logic              found_q, found_d, key_lt;

  // Length clipped to the table depth
  always_comb begin
    if (32'(tab_len_i) > 32'(TABLE_DEPTH)) begin
      len_clip = LW'(TABLE_DEPTH);
    end else begin
      len_clip = LW'(tab_len_i);
    end
  end

  // Probe point and the shared compare
  assign span    = high_q - low_q;
  assign mid     = low_q + (span >> 1);
  assign raddr_o = mid[AW-1:0];
  assign key_ext = CODE_W'(rdata_i);
  assign key_lt  = key_ext < target_q;

  assign stat_o.loop_go  = low_q < high_q;
  assign stat_o.in_range = low_q < len_clip;

  // Bounds and target
  always_comb begin
    low_d    = low_q;
    high_d   = high_q;
    target_d = target_q;
    sl_d     = sl_q;
    found_d  = found_q;
    if (ctrl_i.start) begin
      low_d    = new_batch_i ? '0 : sl_q;
      high_d   = len_clip;
      target_d = code_i >> obj_bits_i;
      found_d  = 1'b0;
    end
    if (ctrl_i.update) begin
      if (key_lt) begin
        low_d = mid + LW'(1);
      end else begin
        high_d = mid;
      end
    end
    if (ctrl_i.finish) begin
      sl_d = low_q;
    end
    if (ctrl_i.check) begin
      found_d = key_ext == target_q;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    high_q   <= high_d;
    target_q <= target_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_q    <= '0;
      found_q <= 1'b0;
    end else begin
      sl_q    <= sl_d;
      found_q <= found_d;
    end
  end

  assign result_o.found    = found_q;
  assign result_o.position = found_q ? POS_W'(low_q) : '0;

endmodule

@@ design/skfo_ctrl.sv @@
module skfo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  skfo_pkg::stat_t   stat_i,
  input  logic              out_free_i,
  output skfo_pkg::ctrl_t   ctrl_o,
  output logic              out_load_o
);

  import skfo_pkg::*;

  state_e state_q, state_d;
  logic   query_acc;

  assign query_acc = in_valid_i && (state_q == ST_IDLE) && (in_op_i == OP_QUERY);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (stat_i.loop_go) begin
          state_d = ST_UPDATE;
        end else if (stat_i.in_range) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UPDATE: state_d = ST_PROBE;
      ST_CHECK:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o     = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.start = query_acc;
      end
      ST_PROBE:  ctrl_o.finish = !stat_i.loop_go;
      ST_UPDATE: ctrl_o.update = 1'b1;
      ST_CHECK:  ctrl_o.check = 1'b1;
      ST_DONE:   out_load_o = out_free_i;
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
